/* src/msgl_pkg.sv */
// Package for the mesh size gradient limiter.
// Holds operation codes, register indexes and the controller/datapath interface types.
// No dependencies.
package msgl_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_SOLVE  = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GRID_ROWS      = 3'd0;
   localparam logic [2:0] CSR_GRID_COLS      = 3'd1;
   localparam logic [2:0] CSR_SPACING        = 3'd2;
   localparam logic [2:0] CSR_GRADIENT_LIMIT = 3'd3;
   localparam logic [2:0] CSR_MIN_SIZE       = 3'd4;
   localparam logic [2:0] CSR_TOLERANCE      = 3'd5;
   localparam logic [2:0] CSR_MAX_SWEEPS     = 3'd6;

   // Configuration reset values.
   localparam logic [6:0]  RST_GRID_ROWS      = 7'd64;
   localparam logic [6:0]  RST_GRID_COLS      = 7'd64;
   localparam logic [31:0] RST_SPACING        = 32'd65536;
   localparam logic [31:0] RST_GRADIENT_LIMIT = 32'd13107;
   localparam logic [31:0] RST_MIN_SIZE       = 32'd65536;
   localparam logic [31:0] RST_TOLERANCE      = 32'd1;
   localparam logic [15:0] RST_MAX_SWEEPS     = 16'd1000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;         // a request is accepted this cycle
      logic start_solve;  // clear residual and sweep count, set up the first cell
      logic rd_cell;      // read the current cell
      logic chk;          // latch the cell size, clear the norm sum
      logic rd_nb;        // read the selected neighbor
      logic nb_take;      // evaluate the neighbor, start a divide if needed
      logic sq;           // square the quotient
      logic acc;          // add the square into the sum
      logic sqrt_go;      // start the square root
      logic mul_go;       // multiply spacing by the excess
      logic upd;          // write the new size, add the change
      logic adv;          // step to the next interior cell
      logic sweep_end;    // count the finished sweep
      logic restart;      // begin another sweep
      logic finish;       // present the solve result
   } msgl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic interior;     // the grid has interior cells
      logic skip;         // the current cell is beyond the distance limit
      logic nb_div;       // this neighbor needs a divide
      logic div_done;
      logic nb_last;      // the fourth neighbor is being accumulated
      logic sqrt_done;
      logic row_last;
      logic col_last;
      logic tol_ok;       // sweep residual at or below tolerance
      logic cap_hit;      // sweep cap reached by this sweep
   } msgl_status_type;

endpackage

/* src/msgl_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// The caller guarantees the high part of the dividend is below the divisor.
// Depends on nothing.
module msgl_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend_hi,
   input  logic [31:0] dividend_lo,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] shr_ff, shr_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   // One compare and subtract step.
   always_comb begin
      trial   = {rem_ff, shr_ff[31]};
      rem_in  = rem_ff;
      shr_in  = shr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend_hi;
         shr_in = dividend_lo;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = 32'(trial - {1'b0, divisor});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         shr_in = {shr_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      shr_ff <= shr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* src/msgl_sqrt.sv */
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// Produces floor(sqrt(value)). Depends on nothing.
module msgl_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] bit_ff, bit_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   // One digit step: try to subtract the partial root plus the current bit.
   always_comb begin
      trial   = r_ff + bit_ff;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         v_in   = value;
         r_in   = '0;
         bit_in = 64'h4000_0000_0000_0000;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

/* src/msgl_datapath.sv */
// Datapath of the mesh size gradient limiter: configuration registers, cell
// memories, index counters, divider, square root, multipliers and result registers.
// Depends on msgl_pkg, msgl_div and msgl_sqrt.
module msgl_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  msgl_pkg::msgl_cmd_type cmd,
   output msgl_pkg::msgl_status_type status,
   input  logic [1:0]             req_op,
   input  logic [11:0]            req_cell_index,
   input  logic [31:0]            req_size_value,
   input  logic signed [31:0]     req_distance,
   input  logic                   csr_write_enable,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_write_data,
   output logic                   rsp_valid,
   output logic [31:0]            rsp_cell_size,
   output logic [15:0]            rsp_sweeps_done,
   output logic                   rsp_converged
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int DWR   = $clog2(MAX_ROWS + 1);
   localparam int DWC   = $clog2(MAX_COLS + 1);
   localparam int DWM   = (DWR > DWC) ? DWR : DWC;
   localparam int DW    = (DWM > 7) ? DWM : 7;

   // Configuration registers.
   logic [6:0]  grid_rows_ff, grid_cols_ff;
   logic [31:0] spacing_ff, gradient_limit_ff, min_size_ff, tolerance_ff;
   logic [15:0] max_sweeps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff      <= msgl_pkg::RST_GRID_ROWS;
         grid_cols_ff      <= msgl_pkg::RST_GRID_COLS;
         spacing_ff        <= msgl_pkg::RST_SPACING;
         gradient_limit_ff <= msgl_pkg::RST_GRADIENT_LIMIT;
         min_size_ff       <= msgl_pkg::RST_MIN_SIZE;
         tolerance_ff      <= msgl_pkg::RST_TOLERANCE;
         max_sweeps_ff     <= msgl_pkg::RST_MAX_SWEEPS;
      end else if (csr_write_enable) begin
         case (csr_index)
            msgl_pkg::CSR_GRID_ROWS:      grid_rows_ff      <= csr_write_data[6:0];
            msgl_pkg::CSR_GRID_COLS:      grid_cols_ff      <= csr_write_data[6:0];
            msgl_pkg::CSR_SPACING:        spacing_ff        <= csr_write_data;
            msgl_pkg::CSR_GRADIENT_LIMIT: gradient_limit_ff <= csr_write_data;
            msgl_pkg::CSR_MIN_SIZE:       min_size_ff       <= csr_write_data;
            msgl_pkg::CSR_TOLERANCE:      tolerance_ff      <= csr_write_data;
            msgl_pkg::CSR_MAX_SWEEPS:     max_sweeps_ff     <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // Effective grid size, spacing and sweep cap.
   logic [DW-1:0] rows_eff, cols_eff;
   logic [31:0]   sp_eff;
   logic [15:0]   cap_eff;

   assign rows_eff = (DW'(grid_rows_ff) > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : DW'(grid_rows_ff);
   assign cols_eff = (DW'(grid_cols_ff) > DW'(MAX_COLS)) ? DW'(MAX_COLS) : DW'(grid_cols_ff);
   assign sp_eff   = (spacing_ff == 32'd0) ? 32'd1 : spacing_ff;
   assign cap_eff  = (max_sweeps_ff == 16'd0) ? 16'd1 : max_sweeps_ff;

   // Cell position within the sweep.
   logic [DW-1:0] row_ff, col_ff;
   logic [AW-1:0] k_ff;
   logic [1:0]    nb_sel_ff;
   logic [AW-1:0] k_first;

   assign k_first = AW'(rows_eff) + AW'(1);

   always_ff @(posedge clock) begin
      if (cmd.start_solve || cmd.restart) begin
         row_ff <= DW'(1);
         col_ff <= DW'(1);
         k_ff   <= k_first;
      end else if (cmd.adv) begin
         if (status.row_last) begin
            row_ff <= DW'(1);
            col_ff <= col_ff + DW'(1);
            k_ff   <= k_ff + AW'(3);
         end else begin
            row_ff <= row_ff + DW'(1);
            k_ff   <= k_ff + AW'(1);
         end
      end
      if (cmd.chk) begin
         nb_sel_ff <= 2'd0;
      end else if (cmd.acc) begin
         nb_sel_ff <= nb_sel_ff + 2'd1;
      end
   end

   // Neighbor address: right, left, below, above in column-major order.
   logic [AW-1:0] nb_addr;

   always_comb begin
      case (nb_sel_ff)
         2'd0:    nb_addr = k_ff + AW'(rows_eff);
         2'd1:    nb_addr = k_ff - AW'(rows_eff);
         2'd2:    nb_addr = k_ff + AW'(1);
         default: nb_addr = k_ff - AW'(1);
      endcase
   end

   // Cell memories: one write and one registered read per cycle.
   logic [31:0]   size_mem [CELLS];
   logic [31:0]   dist_mem [CELLS];
   logic [31:0]   size_rdata_ff, dist_rdata_ff;
   logic [AW-1:0] raddr, waddr;
   logic [31:0]   wdata;
   logic          in_range, load_we, size_we;
   logic [31:0]   new_size;

   assign in_range = 32'(req_cell_index) < 32'(CELLS);
   assign load_we  = cmd.take && (req_op == msgl_pkg::OP_LOAD) && in_range;
   assign size_we  = load_we || cmd.upd;
   assign waddr    = cmd.upd ? k_ff : AW'(req_cell_index);
   assign wdata    = cmd.upd ? new_size : req_size_value;

   always_comb begin
      if (cmd.rd_nb) begin
         raddr = nb_addr;
      end else if (cmd.rd_cell) begin
         raddr = k_ff;
      end else begin
         raddr = AW'(req_cell_index);
      end
   end

   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[waddr] <= wdata;
      end
      if (load_we) begin
         dist_mem[AW'(req_cell_index)] <= req_distance;
      end
      size_rdata_ff <= size_mem[raddr];
      dist_rdata_ff <= dist_mem[raddr];
   end

   // Per-cell arithmetic.
   logic [31:0] h_ff, q_ff, root;
   logic [63:0] sq_ff, sum_ff, prod_ff;
   logic [31:0] diff, excess;
   logic        nb_zero, nb_sat, div_done, sqrt_done;
   logic [31:0] div_q;
   logic [64:0] sum_wide;
   logic [46:0] dec;
   logic [31:0] change;

   assign diff     = h_ff - size_rdata_ff;
   assign nb_zero  = h_ff <= size_rdata_ff;
   assign nb_sat   = {16'd0, diff[31:16]} >= sp_eff;
   assign sum_wide = {1'b0, sum_ff} + {1'b0, sq_ff};
   assign excess   = (root > gradient_limit_ff) ? (root - gradient_limit_ff) : 32'd0;
   assign dec      = prod_ff[63:17];
   assign new_size = (dec >= 47'(h_ff)) ? 32'd0 : (h_ff - dec[31:0]);
   assign change   = h_ff - new_size;

   msgl_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (cmd.nb_take && !nb_zero && !nb_sat),
      .dividend_hi ({16'd0, diff[31:16]}),
      .dividend_lo ({diff[15:0], 16'd0}),
      .divisor     (sp_eff),
      .done        (div_done),
      .quotient    (div_q)
   );

   msgl_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_go),
      .value (sum_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.chk) begin
         h_ff <= size_rdata_ff;
      end
      if (cmd.nb_take) begin
         q_ff <= nb_zero ? 32'd0 : 32'hFFFF_FFFF;
      end else if (div_done) begin
         q_ff <= div_q;
      end
      if (cmd.sq) begin
         sq_ff <= 64'(q_ff) * 64'(q_ff);
      end
      if (cmd.chk) begin
         sum_ff <= '0;
      end else if (cmd.acc) begin
         sum_ff <= sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
      end
      if (cmd.mul_go) begin
         prod_ff <= 64'(sp_eff) * 64'(excess);
      end
   end

   // Residual of the sweep and sweep count.
   logic [47:0] resid_ff;
   logic [15:0] count_ff;
   logic [48:0] resid_wide;
   logic [16:0] count_next;

   assign resid_wide = {1'b0, resid_ff} + 49'(change);
   assign count_next = 17'(count_ff) + 17'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         resid_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.start_solve || cmd.restart) begin
            resid_ff <= '0;
         end else if (cmd.upd) begin
            resid_ff <= resid_wide[48] ? 48'hFFFF_FFFF_FFFF : resid_wide[47:0];
         end
         if (cmd.start_solve) begin
            count_ff <= '0;
         end else if (cmd.sweep_end) begin
            count_ff <= count_next[15:0];
         end
      end
   end

   // Status to the controller.
   assign status.interior  = (rows_eff >= DW'(3)) && (cols_eff >= DW'(3));
   assign status.skip      = !dist_rdata_ff[31]
                             && ({3'd0, dist_rdata_ff[30:0]} > {min_size_ff, 2'b00});
   assign status.nb_div    = !nb_zero && !nb_sat;
   assign status.div_done  = div_done;
   assign status.nb_last   = nb_sel_ff == 2'd3;
   assign status.sqrt_done = sqrt_done;
   assign status.row_last  = row_ff == (rows_eff - DW'(2));
   assign status.col_last  = col_ff == (cols_eff - DW'(2));
   assign status.tol_ok    = resid_ff <= 48'(tolerance_ff);
   assign status.cap_hit   = count_next >= 17'(cap_eff);

   // Result registers.
   logic        rsp_valid_ff, rsp_read_ff, rsp_conv_ff;
   logic [15:0] rsp_sweeps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rsp_read_ff   <= 1'b0;
         rsp_conv_ff   <= 1'b0;
         rsp_sweeps_ff <= '0;
      end else begin
         rsp_valid_ff  <= (cmd.take && (req_op != msgl_pkg::OP_SOLVE)) || cmd.finish;
         rsp_read_ff   <= cmd.take && (req_op == msgl_pkg::OP_READ) && in_range;
         rsp_conv_ff   <= cmd.finish && status.tol_ok;
         rsp_sweeps_ff <= cmd.finish ? count_next[15:0] : 16'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_size   = rsp_read_ff ? size_rdata_ff : 32'd0;
   assign rsp_sweeps_done = rsp_sweeps_ff;
   assign rsp_converged   = rsp_conv_ff;

endmodule

/* src/msgl_ctrl.sv */
// Controller of the mesh size gradient limiter: sequences solve sweeps
// cell by cell and neighbor by neighbor. Depends on msgl_pkg.
module msgl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_op,
   input  msgl_pkg::msgl_status_type status,
   output msgl_pkg::msgl_cmd_type    cmd,
   output logic                      busy
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RDC    = 4'd1;
   localparam logic [3:0] S_CHK    = 4'd2;
   localparam logic [3:0] S_RDN    = 4'd3;
   localparam logic [3:0] S_NB     = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_SQ     = 4'd6;
   localparam logic [3:0] S_ACC    = 4'd7;
   localparam logic [3:0] S_SQRTGO = 4'd8;
   localparam logic [3:0] S_SQRT   = 4'd9;
   localparam logic [3:0] S_MUL    = 4'd10;
   localparam logic [3:0] S_UPD    = 4'd11;
   localparam logic [3:0] S_ADV    = 4'd12;
   localparam logic [3:0] S_SWEEP  = 4'd13;

   logic [3:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.take = 1'b1;
               if (req_op == msgl_pkg::OP_SOLVE) begin
                  cmd.start_solve = 1'b1;
                  state_in = status.interior ? S_RDC : S_SWEEP;
               end
            end
         end
         S_RDC: begin
            cmd.rd_cell = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (status.skip) begin
               state_in = S_ADV;
            end else begin
               cmd.chk = 1'b1;
               state_in = S_RDN;
            end
         end
         S_RDN: begin
            cmd.rd_nb = 1'b1;
            state_in = S_NB;
         end
         S_NB: begin
            cmd.nb_take = 1'b1;
            state_in = status.nb_div ? S_DIV : S_SQ;
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            cmd.sq = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            state_in = status.nb_last ? S_SQRTGO : S_RDN;
         end
         S_SQRTGO: begin
            cmd.sqrt_go = 1'b1;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (status.sqrt_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_go = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            state_in = S_ADV;
         end
         S_ADV: begin
            cmd.adv = 1'b1;
            state_in = (status.row_last && status.col_last) ? S_SWEEP : S_RDC;
         end
         S_SWEEP: begin
            cmd.sweep_end = 1'b1;
            if (status.tol_ok || status.cap_hit) begin
               cmd.finish = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.restart = 1'b1;
               state_in = S_RDC;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

/* src/mesh_size_gradient_limiter_unit.sv */
// Mesh size gradient limiter, top level.
// Joins the controller (msgl_ctrl) and the datapath (msgl_datapath); uses msgl_pkg.
//
// Usage: a request is taken at a rising edge where start is high and busy is
// low; req_op selects load cell, solve or read cell. Every request gives one
// result, shown on the rsp_ ports for a single cycle with rsp_valid high; the
// receiver cannot hold results off, so it must take them as they come.
// Load, read and unused ops return their result in the next cycle and busy
// stays low, so one such request can be taken every cycle.
// A solve raises busy until its result. Each sweep visits every interior cell;
// a skipped cell bypasses the neighbor and root steps, and otherwise each
// neighbor with an unsaturated downward step waits on the bit-serial divider,
// and the square root is waited on as well.
// The grid sits in two single-port-read memories of MAX_ROWS*MAX_COLS words;
// their content is undefined until loaded. Reset clears the control state,
// the result strobe and sets the configuration registers to their defaults.
// Configuration registers must be written through csr_ only while the block is idle; the block does not enforce this.
module mesh_size_gradient_limiter_unit #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [11:0]        req_cell_index,
   input  logic [31:0]        req_size_value,
   input  logic signed [31:0] req_distance,
   output logic               rsp_valid,
   output logic [31:0]        rsp_cell_size,
   output logic [15:0]        rsp_sweeps_done,
   output logic               rsp_converged,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   msgl_pkg::msgl_cmd_type    cmd;
   msgl_pkg::msgl_status_type status;

   // Sequencer.
   msgl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // Storage and arithmetic.
   msgl_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_op           (req_op),
      .req_cell_index   (req_cell_index),
      .req_size_value   (req_size_value),
      .req_distance     (req_distance),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_cell_size    (rsp_cell_size),
      .rsp_sweeps_done  (rsp_sweeps_done),
      .rsp_converged    (rsp_converged)
   );

endmodule

/* src/msgl_checker.sv */
// Port-level checker for the mesh size gradient limiter and its bind.
// Depends on msgl_pkg and mesh_size_gradient_limiter_unit.
module msgl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_op,
   input logic        rsp_valid,
   input logic [31:0] rsp_cell_size,
   input logic [15:0] rsp_sweeps_done,
   input logic        rsp_converged
);

   // A request other than solve is answered in the next cycle.
   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op != msgl_pkg::OP_SOLVE)) |=> (rsp_valid && rsp_sweeps_done == 16'd0))
      else $error("load or read request not answered in the next cycle");

   // A converged solve reports at least one sweep.
   a_conv_sweeps: assert property (@(posedge clock) disable iff (reset)
      rsp_converged |-> (rsp_valid && rsp_sweeps_done != 16'd0))
      else $error("converged flag without a sweep count");

   // A result carries either a cell size or a sweep count, never both.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_size == 32'd0 || rsp_sweeps_done == 16'd0))
      else $error("result mixes a cell size and a sweep count");

   // A solve in progress ends with its result as busy falls.
   a_solve_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_sweeps_done != 16'd0))
      else $error("solve ended without a result");

endmodule

bind mesh_size_gradient_limiter_unit msgl_checker u_msgl_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_op          (req_op),
   .rsp_valid       (rsp_valid),
   .rsp_cell_size   (rsp_cell_size),
   .rsp_sweeps_done (rsp_sweeps_done),
   .rsp_converged   (rsp_converged)
);
